FILE: design/wide_unsigned_signed_divider_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 256-bit divider checker
// Shared property shapes for the port-level checks.
// ----------------------------------------------------------------------------
`ifndef WIDE_UNSIGNED_SIGNED_DIVIDER_DEFINES_SVH
`define WIDE_UNSIGNED_SIGNED_DIVIDER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define WUSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (!rst && (ante)) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define WUSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (!rst && (ante)) |=> (cons)) else $error(msg);

`endif

FILE: design/wusd_pkg.sv
// ----------------------------------------------------------------------------
// wusd_pkg
// Shared types and constants for the 256-bit unsigned/signed divider.
// ----------------------------------------------------------------------------
package wusd_pkg;

  localparam int LIMB_W = 64;
  localparam int NUM_LIMBS = 4;
  localparam int WORD_W = LIMB_W * NUM_LIMBS;
  localparam int CNT_W = $clog2(WORD_W);

  typedef enum logic [1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEGA,
    ST_NEGB,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic neg_a;
    logic neg_b;
    logic step;
    logic fix;
  } dp_cmd_t;

endpackage

FILE: design/wide_unsigned_signed_divider.sv
// done pulses for one cycle once the sequencer has finished a transaction taken on start.
// A new transaction is taken only while not busy; start is taken again in the done cycle.
// The sequence is operand negation (ST_NEGA, ST_NEGB), 256 radix-2 steps through one
// 257-bit subtractor, a result fixup on a shared negator (ST_FIX) and the done state (ST_DONE).
// Reset (rst, synchronous) returns the sequencer to idle; done stays low until a result.
// Results are flagged by done for exactly one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// wide_unsigned_signed_divider
// 256-bit unsigned/signed quotient and remainder, zero divisor gives zero.
// ----------------------------------------------------------------------------
module wide_unsigned_signed_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic [1:0]                  op,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb0,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb1,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb2,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb3,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb0,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb1,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb2,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb3,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb0,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb1,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb2,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb3
);

  wusd_pkg::dp_cmd_t cmd;

  wusd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  wusd_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .op           (op),
    .a_limb0      (a_limb0),
    .a_limb1      (a_limb1),
    .a_limb2      (a_limb2),
    .a_limb3      (a_limb3),
    .b_limb0      (b_limb0),
    .b_limb1      (b_limb1),
    .b_limb2      (b_limb2),
    .b_limb3      (b_limb3),
    .result_limb0 (result_limb0),
    .result_limb1 (result_limb1),
    .result_limb2 (result_limb2),
    .result_limb3 (result_limb3)
  );

endmodule

FILE: design/wusd_ctrl.sv
// ----------------------------------------------------------------------------
// wusd_ctrl
// Sequencer: operand sign conversion, 256 restoring steps, result fixup.
// ----------------------------------------------------------------------------
module wusd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  output wusd_pkg::dp_cmd_t        cmd
);

  wusd_pkg::state_t                state, state_next;
  logic [wusd_pkg::CNT_W-1:0]      cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wusd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      wusd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = wusd_pkg::ST_NEGA;
        end
      end
      wusd_pkg::ST_NEGA: begin
        cmd.neg_a  = 1'b1;
        state_next = wusd_pkg::ST_NEGB;
      end
      wusd_pkg::ST_NEGB: begin
        cmd.neg_b  = 1'b1;
        cnt_next   = '1;
        state_next = wusd_pkg::ST_DIV;
      end
      wusd_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = wusd_pkg::ST_FIX;
        end
      end
      wusd_pkg::ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = wusd_pkg::ST_DONE;
      end
      wusd_pkg::ST_DONE: begin
        // result register holds, so a new transaction may start here
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = wusd_pkg::ST_NEGA;
        end else begin
          state_next = wusd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wusd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/wusd_dp.sv
// ----------------------------------------------------------------------------
// wusd_dp
// Operand registers, shared 256-bit negator and 257-bit restoring subtractor.
// ----------------------------------------------------------------------------
module wusd_dp (
  input  logic                        clk,
  input  wusd_pkg::dp_cmd_t           cmd,
  input  logic [1:0]                  op,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb0,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb1,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb2,
  input  logic [wusd_pkg::LIMB_W-1:0] a_limb3,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb0,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb1,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb2,
  input  logic [wusd_pkg::LIMB_W-1:0] b_limb3,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb0,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb1,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb2,
  output logic [wusd_pkg::LIMB_W-1:0] result_limb3
);

  localparam int W = wusd_pkg::WORD_W;
  localparam int L = wusd_pkg::LIMB_W;

  wusd_pkg::op_t  op_r;
  logic           a_neg, b_neg, b_zero;
  logic [W-1:0]   quo;   // holds the dividend, shifted out as quotient bits enter
  logic [W-1:0]   rem;
  logic [W-1:0]   div;
  logic [W-1:0]   res;

  logic [W-1:0]   neg_in, neg_out;
  logic [W-1:0]   shifted;
  logic [W:0]     diff;
  logic           take;
  logic           want_quo, need_fix;
  logic [W-1:0]   sel;

  assign want_quo = (op_r == wusd_pkg::OP_UQUO) || (op_r == wusd_pkg::OP_SQUO);
  assign need_fix = ((op_r == wusd_pkg::OP_SQUO) && (a_neg ^ b_neg)) ||
                    ((op_r == wusd_pkg::OP_SREM) && a_neg);
  assign sel      = want_quo ? quo : rem;

  // single two's-complement negator shared by all sign steps
  always_comb begin
    if (cmd.neg_b) begin
      neg_in = div;
    end else if (cmd.fix) begin
      neg_in = sel;
    end else begin
      neg_in = quo;
    end
  end
  assign neg_out = ~neg_in + {{(W-1){1'b0}}, 1'b1};

  // one restoring step; a carried-out top bit always permits the subtract
  assign shifted = {rem[W-2:0], quo[W-1]};
  assign diff    = {rem[W-1], shifted} - {1'b0, div};
  assign take    = ~diff[W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= wusd_pkg::op_t'(op);
      quo    <= {a_limb3, a_limb2, a_limb1, a_limb0};
      div    <= {b_limb3, b_limb2, b_limb1, b_limb0};
      rem    <= '0;
      a_neg  <= op[1] & a_limb3[L-1];
      b_neg  <= op[1] & b_limb3[L-1];
      b_zero <= ~|{b_limb3, b_limb2, b_limb1, b_limb0};
    end
    if (cmd.neg_a && a_neg) begin
      quo <= neg_out;
    end
    if (cmd.neg_b && b_neg) begin
      div <= neg_out;
    end
    if (cmd.step) begin
      rem <= take ? diff[W-1:0] : shifted;
      quo <= {quo[W-2:0], take};
    end
    if (cmd.fix) begin
      if (b_zero) begin
        res <= '0;
      end else begin
        res <= need_fix ? neg_out : sel;
      end
    end
  end

  assign result_limb0 = res[L-1:0];
  assign result_limb1 = res[2*L-1:L];
  assign result_limb2 = res[3*L-1:2*L];
  assign result_limb3 = res[4*L-1:3*L];

endmodule

FILE: design/wusd_chk.sv
// ----------------------------------------------------------------------------
// wusd_chk
// Port-level checks on the divider's start/busy/done sequencing.
// ----------------------------------------------------------------------------
`include "wide_unsigned_signed_divider_defines.svh"

module wusd_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [wusd_pkg::LIMB_W-1:0] result_limb0,
  input logic [wusd_pkg::LIMB_W-1:0] result_limb1,
  input logic [wusd_pkg::LIMB_W-1:0] result_limb2,
  input logic [wusd_pkg::LIMB_W-1:0] result_limb3
);

  // an accepted transaction always goes busy next cycle
  `WUSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")

  // a result strobe is always a single pulse, never held high
  `WUSD_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

  // the strobe only appears when a new transaction can be taken
  `WUSD_ASSERT_NOW(a_done_idle, done, !busy, "done raised while busy")

  // result stays put the cycle after the strobe when no new work was taken
  `WUSD_ASSERT_NEXT(a_res_hold, done && !start, $stable(result_limb0) && $stable(result_limb1) && $stable(result_limb2) && $stable(result_limb3), "result changed after done")

endmodule

bind wide_unsigned_signed_divider wusd_chk u_wusd_chk (.*);
